/* design/rgbconv_pkg.sv */
`default_nettype none

package rgbconv_pkg;

  // line store depth
  localparam int MAX_WIDTH_DEF = 2048;

  // configuration register indexes (byte address / 8)
  localparam logic [2:0] REG_WIDTH     = 3'd0;
  localparam logic [2:0] REG_HEIGHT    = 3'd1;
  localparam logic [2:0] REG_TAPS_LOW  = 3'd2;
  localparam logic [2:0] REG_TAPS_MID  = 3'd3;
  localparam logic [2:0] REG_TAP_LAST  = 3'd4;

  // register reset values: sharpen kernel, 640x480
  localparam logic [11:0] WIDTH_RST     = 12'd640;
  localparam logic [15:0] HEIGHT_RST    = 16'd480;
  localparam logic [63:0] TAPS_LOW_RST  = 64'hFF00_0000_FF00_0000;
  localparam logic [63:0] TAPS_MID_RST  = 64'hFF00_0000_FF00_0500;
  localparam logic [15:0] TAP_LAST_RST  = 16'h0000;

  // datapath widths
  localparam int PIX_W  = 24;
  localparam int PROD_W = 25;  // 9-bit signed pixel times 16-bit tap
  localparam int PSUM_W = 27;  // one window column against one tap column
  localparam int SUM_W  = 29;  // three columns plus rounding
  localparam logic [SUM_W-1:0] ROUND_HALF = SUM_W'(128);

  // result buffer
  localparam int FIFO_DEPTH = 16;

  typedef struct packed {
    logic first;   // column 0 of the row
    logic row1;    // second pixel row, top replicates middle
    logic has_row; // row 1 or later, results possible
    logic last;    // last column of the row
    logic drain;   // drain row
  } item_flags_t;

  typedef struct packed {
    logic [PIX_W-1:0] pix;
    logic             frame_end;
    logic             run_last;
  } result_t;

  typedef struct packed {
    logic    two;
    result_t a;
    result_t b;
  } entry_t;

endpackage

`default_nettype wire

/* design/rgbconv_ram.sv */
`default_nettype none

module rgbconv_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 2048,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read returns the old word on a same-address write
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* design/rgb_3x3_convolution_replicate_edge.sv */
`default_nettype none

// 3x3 convolution of an RGB888 raster stream with replicated borders. Pixels enter on the
// in_ stream, red in the low byte; each channel is filtered with the same nine signed Q8.8
// taps (row-major, APB byte addresses 0x10..0x20), rounded half up and saturated to 0..255.
// Output pixel (R, C) leaves after input (R+1, C+1); the last input of each row yields two
// results (one if W is 1), the second carrying tlast. After H pixel rows send one drain row
// of W items (data ignored) to flush the bottom row; its last result has tuser set. The
// first pixel row produces no results. Throughput is one pixel per clock while in_tready is
// high: the two line stores share one 48-bit single-port-read RAM, read when a pixel is
// accepted and written back the following cycle, with a forwarding register covering a
// one-pixel-wide image. Results fill a 16-entry output buffer; in_tready drops only when
// that buffer plus the pixels in flight could overflow it. The line stores need no clearing
// after reset. Registers should be written only while the stream is idle.
module rgb_3x3_convolution_replicate_edge #(
  parameter int MAX_WIDTH = rgbconv_pkg::MAX_WIDTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // pixel input
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,    // red_in[7:0], green_in[15:8], blue_in[23:16]
  // filtered output
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [23:0] out_tdata,   // red_out[7:0], green_out[15:8], blue_out[23:16]
  output logic      [0:0]  out_tuser,   // frame_end[0]
  output logic             out_tlast,   // run_last
  // configuration
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [5:0]  cfg_paddr,
  input  wire logic [63:0] cfg_pwdata,
  output logic      [63:0] cfg_prdata,
  output logic             cfg_pready
);

  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int WW = ($clog2(MAX_WIDTH + 1) > 12) ? $clog2(MAX_WIDTH + 1) : 12;
  localparam int PW = rgbconv_pkg::PIX_W;
  localparam int PROD_W = rgbconv_pkg::PROD_W;
  localparam int PSUM_W = rgbconv_pkg::PSUM_W;
  localparam int SUM_W = rgbconv_pkg::SUM_W;
  localparam int FD = rgbconv_pkg::FIFO_DEPTH;
  localparam int FP = $clog2(FD);

  // ------------------------------------------------------------------
  // configuration registers
  // ------------------------------------------------------------------
  logic [11:0] width_r;
  logic [15:0] height_r;
  logic [63:0] taps_low_r;
  logic [63:0] taps_mid_r;
  logic [15:0] tap_last_r;
  logic        cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r    <= rgbconv_pkg::WIDTH_RST;
      height_r   <= rgbconv_pkg::HEIGHT_RST;
      taps_low_r <= rgbconv_pkg::TAPS_LOW_RST;
      taps_mid_r <= rgbconv_pkg::TAPS_MID_RST;
      tap_last_r <= rgbconv_pkg::TAP_LAST_RST;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[5:3])
        rgbconv_pkg::REG_WIDTH:    width_r    <= cfg_pwdata[11:0];
        rgbconv_pkg::REG_HEIGHT:   height_r   <= cfg_pwdata[15:0];
        rgbconv_pkg::REG_TAPS_LOW: taps_low_r <= cfg_pwdata;
        rgbconv_pkg::REG_TAPS_MID: taps_mid_r <= cfg_pwdata;
        rgbconv_pkg::REG_TAP_LAST: tap_last_r <= cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[5:3])
      rgbconv_pkg::REG_WIDTH:    cfg_prdata = 64'(width_r);
      rgbconv_pkg::REG_HEIGHT:   cfg_prdata = 64'(height_r);
      rgbconv_pkg::REG_TAPS_LOW: cfg_prdata = taps_low_r;
      rgbconv_pkg::REG_TAPS_MID: cfg_prdata = taps_mid_r;
      rgbconv_pkg::REG_TAP_LAST: cfg_prdata = 64'(tap_last_r);
      default:                   cfg_prdata = '0;
    endcase
  end

  // nine taps, row-major
  logic signed [15:0] tap [9];

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      tap[k]     = $signed(taps_low_r[16*k +: 16]);
      tap[k + 4] = $signed(taps_mid_r[16*k +: 16]);
    end
    tap[8] = $signed(tap_last_r);
  end

  // effective frame size: zero acts as one, width capped at the store depth
  logic [WW-1:0] w_eff;
  logic [15:0]   h_eff;

  always_comb begin
    if (width_r == '0) begin
      w_eff = WW'(1);
    end else if (WW'(width_r) > WW'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(width_r);
    end
    h_eff = (height_r == '0) ? 16'd1 : height_r;
  end

  // ------------------------------------------------------------------
  // accept stage: position counters and line store read
  // ------------------------------------------------------------------
  logic [CW-1:0] col_r;
  logic [15:0]   row_r;
  logic          in_acc;
  logic          last_col;
  logic          drain;

  assign in_acc   = in_tvalid & in_tready;
  assign last_col = ((WW + 1)'(col_r) + (WW + 1)'(1)) >= (WW + 1)'(w_eff);
  assign drain    = row_r >= h_eff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (in_acc) begin
      if (last_col) begin
        col_r <= '0;
        row_r <= drain ? 16'd0 : row_r + 16'd1;
      end else begin
        col_r <= col_r + CW'(1);
      end
    end
  end

  // ------------------------------------------------------------------
  // stage 1: line store data back, build the new window column, write back
  // ------------------------------------------------------------------
  logic                     s1_valid_r;
  logic [CW-1:0]            s1_addr_r;
  logic [PW-1:0]            s1_px_r;
  rgbconv_pkg::item_flags_t s1_flags_r;

  logic [2*PW-1:0] ram_rdata;
  logic [2*PW-1:0] line_word;
  logic [2*PW-1:0] wr_word;
  logic [PW-1:0]   top_px;
  logic [PW-1:0]   mid_px;
  logic [PW-1:0]   bot_px;

  // last write, for a read that was issued in the same cycle at the same entry
  logic            fwd_valid_r;
  logic [CW-1:0]   fwd_addr_r;
  logic [2*PW-1:0] fwd_word_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= in_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_addr_r        <= col_r;
      s1_px_r          <= in_tdata;
      s1_flags_r.first <= col_r == '0;
      s1_flags_r.row1  <= row_r == 16'd1;
      s1_flags_r.has_row <= row_r != '0;
      s1_flags_r.last  <= last_col;
      s1_flags_r.drain <= drain;
    end
  end

  rgbconv_ram #(
    .WIDTH (2 * PW),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk   (clk),
    .we    (s1_valid_r),
    .waddr (s1_addr_r),
    .wdata (wr_word),
    .re    (in_acc),
    .raddr (col_r),
    .rdata (ram_rdata)
  );

  always_comb begin
    line_word = (fwd_valid_r && fwd_addr_r == s1_addr_r) ? fwd_word_r : ram_rdata;
    mid_px    = line_word[PW-1:0];
    // older store gets the middle row, newer store the incoming pixel
    wr_word   = {mid_px, s1_px_r};
    top_px    = s1_flags_r.row1 ? mid_px : line_word[2*PW-1:PW];
    bot_px    = s1_flags_r.drain ? mid_px : s1_px_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_valid_r <= 1'b0;
    end else begin
      fwd_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    fwd_addr_r <= s1_addr_r;
    fwd_word_r <= wr_word;
  end

  // ------------------------------------------------------------------
  // stage 2: window column (top, middle, bottom)
  // ------------------------------------------------------------------
  logic                     s2_valid_r;
  logic [PW-1:0]            s2_col_r [3];
  rgbconv_pkg::item_flags_t s2_flags_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    s2_col_r[0] <= top_px;
    s2_col_r[1] <= mid_px;
    s2_col_r[2] <= bot_px;
    s2_flags_r  <= s1_flags_r;
  end

  // ------------------------------------------------------------------
  // stage 3: each column pixel against each tap column, per channel
  // ------------------------------------------------------------------
  logic                     s3_valid_r;
  logic signed [PROD_W-1:0] s3_prod_r [3][3][3];  // [channel][row][tap column]
  rgbconv_pkg::item_flags_t s3_flags_r;
  logic signed [PROD_W-1:0] prod [3][3][3];

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      for (int rw = 0; rw < 3; rw++) begin
        for (int j = 0; j < 3; j++) begin
          prod[ch][rw][j] = PROD_W'($signed({1'b0, s2_col_r[rw][8*ch +: 8]}))
                          * PROD_W'(tap[rw*3 + j]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else begin
      s3_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    s3_prod_r  <= prod;
    s3_flags_r <= s2_flags_r;
  end

  // ------------------------------------------------------------------
  // stage 4: column partial sums, one per channel and tap column
  // ------------------------------------------------------------------
  logic                     s4_valid_r;
  logic signed [PSUM_W-1:0] s4_psum_r [3][3];  // [channel][tap column]
  rgbconv_pkg::item_flags_t s4_flags_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_valid_r <= 1'b0;
    end else begin
      s4_valid_r <= s3_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int ch = 0; ch < 3; ch++) begin
      for (int j = 0; j < 3; j++) begin
        s4_psum_r[ch][j] <= PSUM_W'(s3_prod_r[ch][0][j]) + PSUM_W'(s3_prod_r[ch][1][j])
                          + PSUM_W'(s3_prod_r[ch][2][j]);
      end
    end
    s4_flags_r <= s3_flags_r;
  end

  // ------------------------------------------------------------------
  // stage 5: combine with the two previous columns' partial sums
  // ------------------------------------------------------------------
  // hist1 is the column left of the current one, hist2 the one before it;
  // at column 0 both take the current column (left edge replication)
  logic signed [PSUM_W-1:0] hist1_r [3][3];
  logic signed [PSUM_W-1:0] hist2_r [3][3];

  logic                     s5_valid_r;
  logic signed [SUM_W-1:0]  s5_sum1_r [3];  // full window left, middle, right
  logic signed [SUM_W-1:0]  s5_sum2_r [3];  // right edge: middle, right, right
  rgbconv_pkg::item_flags_t s5_flags_r;
  logic signed [PSUM_W-1:0] mid_left [3];

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      mid_left[ch] = s4_flags_r.first ? s4_psum_r[ch][0] : hist1_r[ch][0];
    end
  end

  always_ff @(posedge clk) begin
    if (s4_valid_r) begin
      if (s4_flags_r.first) begin
        hist1_r <= s4_psum_r;
        hist2_r <= s4_psum_r;
      end else begin
        hist1_r <= s4_psum_r;
        hist2_r <= hist1_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_valid_r <= 1'b0;
    end else begin
      s5_valid_r <= s4_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int ch = 0; ch < 3; ch++) begin
      s5_sum1_r[ch] <= SUM_W'(hist2_r[ch][0]) + SUM_W'(hist1_r[ch][1])
                     + SUM_W'(s4_psum_r[ch][2]) + $signed(rgbconv_pkg::ROUND_HALF);
      s5_sum2_r[ch] <= SUM_W'(mid_left[ch]) + SUM_W'(s4_psum_r[ch][1])
                     + SUM_W'(s4_psum_r[ch][2]) + $signed(rgbconv_pkg::ROUND_HALF);
    end
    s5_flags_r <= s4_flags_r;
  end

  // drop the fraction and clamp to 0..255
  function automatic logic [7:0] saturate(input logic signed [SUM_W-1:0] s);
    logic [7:0] v;
    if (s[SUM_W-1]) begin
      v = 8'd0;
    end else if (|s[SUM_W-2:16]) begin
      v = 8'd255;
    end else begin
      v = s[15:8];
    end
    return v;
  endfunction

  rgbconv_pkg::result_t res1;
  rgbconv_pkg::result_t res2;
  rgbconv_pkg::entry_t  push_entry;
  logic                 has1;
  logic                 has2;
  logic                 push;

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      res1.pix[8*ch +: 8] = saturate(s5_sum1_r[ch]);
      res2.pix[8*ch +: 8] = saturate(s5_sum2_r[ch]);
    end
    res1.frame_end = 1'b0;
    res1.run_last  = ~s5_flags_r.last;
    res2.frame_end = s5_flags_r.drain;
    res2.run_last  = 1'b1;
    has1 = s5_flags_r.has_row & ~s5_flags_r.first;
    has2 = s5_flags_r.has_row & s5_flags_r.last;
    push = s5_valid_r & (has1 | has2);
    push_entry.two = has1 & has2;
    push_entry.a   = has1 ? res1 : res2;
    push_entry.b   = res2;
  end

  // ------------------------------------------------------------------
  // result buffer: one entry per result-producing pixel, holding one or two results
  // ------------------------------------------------------------------
  rgbconv_pkg::entry_t fifo_r [FD];
  logic [FP-1:0]       wr_ptr_r;
  logic [FP-1:0]       rd_ptr_r;
  logic [FP:0]         count_r;
  logic                phase_r;  // second result of the head entry is next
  logic                pop;
  logic [FP+1:0]       committed;
  rgbconv_pkg::entry_t head;

  always_comb begin
    committed = (FP + 2)'(count_r) + (FP + 2)'(s1_valid_r) + (FP + 2)'(s2_valid_r)
              + (FP + 2)'(s3_valid_r) + (FP + 2)'(s4_valid_r) + (FP + 2)'(s5_valid_r);
    in_tready = committed < (FP + 2)'(FD);
  end

  assign head       = fifo_r[rd_ptr_r];
  assign out_tvalid = count_r != '0;
  assign out_tdata  = phase_r ? head.b.pix : head.a.pix;
  assign out_tuser  = phase_r ? head.b.frame_end : head.a.frame_end;
  assign out_tlast  = phase_r ? head.b.run_last : head.a.run_last;
  assign pop        = out_tvalid & out_tready & (phase_r | ~head.two);

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
      phase_r  <= 1'b0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + FP'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + FP'(1);
      end
      count_r <= count_r + (FP + 1)'(push) - (FP + 1)'(pop);
      if (out_tvalid && out_tready) begin
        phase_r <= ~pop;
      end
    end
  end

endmodule

`default_nettype wire

/* dv/rgb_3x3_convolution_replicate_edge_tb.sv */
`timescale 1ns / 100ps

module rgb_3x3_convolution_replicate_edge_tb;

  localparam int LINE_DEPTH    = rgbconv_pkg::MAX_WIDTH_DEF;
  localparam int SETTLE_CYCLES = 20;    // well past the pipeline depth
  localparam int HOLD_CYCLES   = 400;   // long enough to fill the output buffer
  localparam int RANDOM_ITEMS  = 800;

  typedef enum int {PX_RANDOM, PX_EXTREME, PX_GRAY} px_style_t;
  typedef enum int {TAPS_RANDOM, TAPS_MODEST, TAPS_EXTREME} taps_style_t;

  // one pending input transfer: pixel plus idle cycles before it is offered
  typedef struct packed {
    logic [23:0] pix;
    logic [1:0]  gap;
  } source_px_t;

  typedef struct {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       frame_end;
    logic       run_last;
  } filtered_px_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic [0:0]  out_tuser;
  logic        out_tlast;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [5:0]  cfg_paddr = '0;
  logic [63:0] cfg_pwdata = '0;
  logic [63:0] cfg_prdata;
  logic        cfg_pready;

  // predictor copy of the registers, starting from their reset values
  logic [11:0] width_reg    = rgbconv_pkg::WIDTH_RST;
  logic [15:0] height_reg   = rgbconv_pkg::HEIGHT_RST;
  logic [63:0] taps_low_reg = rgbconv_pkg::TAPS_LOW_RST;
  logic [63:0] taps_mid_reg = rgbconv_pkg::TAPS_MID_RST;
  logic [15:0] tap_last_reg = rgbconv_pkg::TAP_LAST_RST;

  // predictor copy of the line stores, window and raster position
  bit   [23:0] line_older [LINE_DEPTH];
  bit   [23:0] line_newer [LINE_DEPTH];
  bit   [23:0] win_px [9];  // index col*3 + row, col 0 = left, row 0 = top
  int          col_cnt = 0;
  int          row_cnt = 0;

  source_px_t   source_q [$];
  filtered_px_t expected_q [$];
  source_px_t   next_src;
  filtered_px_t sink_want;

  int gap_wait = 0;
  int stall_left = 0;
  int results_seen = 0;
  bit out_stall_on = 1'b1;
  int hold_asks = 0;
  int hold_served = 0;
  int mismatches = 0;

  rgb_3x3_convolution_replicate_edge dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always #5 clk = ~clk;

  // zero acts as one, anything past the line depth is clamped
  function automatic int eff_width();
    if (width_reg == 0) return 1;
    if (width_reg > LINE_DEPTH) return LINE_DEPTH;
    return width_reg;
  endfunction

  function automatic int eff_height();
    return (height_reg == 0) ? 1 : height_reg;
  endfunction

  function automatic logic signed [15:0] kernel_tap(int k);
    if (k < 4) return taps_low_reg[16*k +: 16];
    if (k < 8) return taps_mid_reg[16*(k-4) +: 16];
    return tap_last_reg;
  endfunction

  // convolve three window columns, per channel, round half up and clamp
  function automatic logic [23:0] filter_window(int left, int center, int right);
    int          cols [3];
    int          ch;
    int          r;
    int          c;
    longint      acc;
    logic [23:0] res;
    cols[0] = left;
    cols[1] = center;
    cols[2] = right;
    for (ch = 0; ch < 3; ch++) begin
      acc = 128;
      for (r = 0; r < 3; r++)
        for (c = 0; c < 3; c++)
          acc += longint'(win_px[cols[c] + r][8*ch +: 8]) * longint'(kernel_tap(3*r + c));
      if (acc < 0) res[8*ch +: 8] = 8'd0;
      else if (acc >= 65536) res[8*ch +: 8] = 8'd255;
      else res[8*ch +: 8] = acc[15:8];
    end
    return res;
  endfunction

  // advance the raster by one accepted pixel and queue the pixels it completes
  function automatic void apply_pixel(logic [23:0] pix);
    int           idx;
    int           i;
    logic         last_col;
    logic         drain;
    logic [23:0]  top;
    logic [23:0]  mid;
    logic [23:0]  bot;
    filtered_px_t res;
    last_col = (col_cnt + 1 >= eff_width());
    drain    = (row_cnt >= eff_height());
    idx = (col_cnt < LINE_DEPTH) ? col_cnt : LINE_DEPTH - 1;
    top = line_older[idx];
    mid = line_newer[idx];
    line_older[idx] = mid;
    line_newer[idx] = pix;
    // top edge replicates row 0, the drain row replicates the bottom row
    if (row_cnt == 1) top = mid;
    bot = drain ? mid : pix;
    if (col_cnt == 0) begin
      // left edge: every window column is the first column
      for (i = 0; i < 9; i += 3) begin
        win_px[i]     = top;
        win_px[i + 1] = mid;
        win_px[i + 2] = bot;
      end
    end else begin
      for (i = 0; i < 6; i++) win_px[i] = win_px[i + 3];
      win_px[6] = top;
      win_px[7] = mid;
      win_px[8] = bot;
    end
    if (row_cnt >= 1) begin
      if (col_cnt >= 1) begin
        {res.blue, res.green, res.red} = filter_window(0, 3, 6);
        res.frame_end = 1'b0;
        res.run_last  = !last_col;
        expected_q.insert(expected_q.size(), res);
      end
      if (last_col) begin
        // right edge: last column stands in for column W
        {res.blue, res.green, res.red} = filter_window(3, 6, 6);
        res.frame_end = drain;
        res.run_last  = 1'b1;
        expected_q.insert(expected_q.size(), res);
      end
    end
    if (last_col) begin
      col_cnt = 0;
      row_cnt = drain ? 0 : (row_cnt + 1) & 16'hFFFF;
    end else begin
      col_cnt = (col_cnt + 1) & 16'h7FFF;
    end
  endfunction

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  function automatic logic [23:0] pick_pixel(px_style_t style);
    logic [7:0] g;
    case (style)
      PX_RANDOM: return 24'($urandom);
      PX_EXTREME: return {($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00,
                          ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00,
                          ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00};
      default: begin
        g = 8'($urandom);
        return {g, g, g};
      end
    endcase
  endfunction

  function automatic logic [15:0] pick_tap(taps_style_t style);
    case (style)
      TAPS_RANDOM: return 16'($urandom);
      // roughly -1.5 .. +1.5, keeps most sums inside 0..255
      TAPS_MODEST: return 16'(int'($urandom_range(0, 768)) - 384);
      default: begin
        case ($urandom_range(0, 3))
          0: return 16'h7FFF;
          1: return 16'h8000;
          2: return 16'h0100;
          default: return 16'h0000;
        endcase
      end
    endcase
  endfunction

  // pixel source: one transfer at a time from source_q, idling as each item asks
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      gap_wait = 0;
    end else begin
      if (in_tvalid && in_tready) apply_pixel(in_tdata);
      if (!in_tvalid || in_tready) begin
        if (source_q.size() != 0 && gap_wait >= source_q[0].gap) begin
          next_src = source_q.pop_front();
          in_tdata  <= next_src.pix;
          in_tvalid <= 1'b1;
          gap_wait = 0;
        end else begin
          in_tvalid <= 1'b0;
          if (source_q.size() != 0) gap_wait++;
        end
      end
    end
  end

  // result sink: compare each transfer with the oldest expected pixel
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_q.size() == 0) begin
          $error("output transfer with nothing expected: tdata %h", out_tdata);
          mismatches++;
        end else begin
          sink_want = expected_q.pop_front();
          check_field("red_out", sink_want.red, out_tdata[7:0]);
          check_field("green_out", sink_want.green, out_tdata[15:8]);
          check_field("blue_out", sink_want.blue, out_tdata[23:16]);
          check_field("frame_end", sink_want.frame_end, out_tuser[0]);
          check_field("run_last", sink_want.run_last, out_tlast);
        end
        results_seen++;
        // switch between stalling and streaming now and then
        if (results_seen % 64 == 0) out_stall_on = ($urandom_range(0, 2) != 0);
        stall_left = out_stall_on ? $urandom_range(0, 3) : 0;
      end
      // long hold-off on request, so the block backs up into in_tready
      if (hold_served != hold_asks) begin
        hold_served = hold_asks;
        stall_left  = HOLD_CYCLES;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // apb write: setup then access, predictor register updated once it lands
  task automatic cfg_write(logic [2:0] idx, logic [63:0] value);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 3'b000};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    case (idx)
      rgbconv_pkg::REG_WIDTH:    width_reg    = value[11:0];
      rgbconv_pkg::REG_HEIGHT:   height_reg   = value[15:0];
      rgbconv_pkg::REG_TAPS_LOW: taps_low_reg = value;
      rgbconv_pkg::REG_TAPS_MID: taps_mid_reg = value;
      rgbconv_pkg::REG_TAP_LAST: tap_last_reg = value[15:0];
      default: ;
    endcase
  endtask

  task automatic load_kernel(taps_style_t style);
    cfg_write(rgbconv_pkg::REG_TAPS_LOW,
              {pick_tap(style), pick_tap(style), pick_tap(style), pick_tap(style)});
    cfg_write(rgbconv_pkg::REG_TAPS_MID,
              {pick_tap(style), pick_tap(style), pick_tap(style), pick_tap(style)});
    cfg_write(rgbconv_pkg::REG_TAP_LAST, {32'($urandom), 16'($urandom), pick_tap(style)});
  endtask

  task automatic queue_pixels(int count, px_style_t style, bit burst);
    source_px_t item;
    int i;
    for (i = 0; i < count; i++) begin
      item.pix = pick_pixel(style);
      item.gap = burst ? 2'd0 : 2'($urandom_range(0, 3));
      source_q.insert(source_q.size(), item);
    end
  endtask

  // sampled on the falling edge, when source, valid and expectations agree
  task automatic wait_drained();
    do @(negedge clk); while (source_q.size() != 0 || in_tvalid || expected_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin : stimulus
    source_px_t  item;
    logic [23:0] corner_px [9];
    int          random_items;
    int          n;
    int          v;
    bit          fresh;
    corner_px = '{24'h000000, 24'hFFFFFF, 24'h00FF00, 24'hFF00FF, 24'h55AA55,
                  24'hAA55AA, 24'h010101, 24'h808080, 24'hFE7F01};
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // reset sharpen kernel over a 3x2 frame of corner-case pixels plus drain row
    cfg_write(rgbconv_pkg::REG_WIDTH, 64'd3);
    cfg_write(rgbconv_pkg::REG_HEIGHT, 64'd2);
    foreach (corner_px[i]) begin
      item.pix = corner_px[i];
      item.gap = 2'($urandom_range(0, 3));
      source_q.insert(source_q.size(), item);
    end
    wait_drained();

    // one-pixel frame, all taps at the positive limit
    cfg_write(rgbconv_pkg::REG_TAPS_LOW, {4{16'h7FFF}});
    cfg_write(rgbconv_pkg::REG_TAPS_MID, {4{16'h7FFF}});
    cfg_write(rgbconv_pkg::REG_TAP_LAST, 64'h7FFF);
    cfg_write(rgbconv_pkg::REG_WIDTH, 64'd1);
    cfg_write(rgbconv_pkg::REG_HEIGHT, 64'd1);
    queue_pixels(2, PX_EXTREME, 1'b0);
    wait_drained();

    // zero width and height act as one, taps at the negative limit, junk upper bits
    cfg_write(rgbconv_pkg::REG_TAPS_LOW, {4{16'h8000}});
    cfg_write(rgbconv_pkg::REG_TAPS_MID, {4{16'h8000}});
    cfg_write(rgbconv_pkg::REG_TAP_LAST, 64'hFFFF_FFFF_FFFF_8000);
    cfg_write(rgbconv_pkg::REG_WIDTH, 64'hFFFF_FFFF_FFFF_F000);
    cfg_write(rgbconv_pkg::REG_HEIGHT, 64'hFFFF_FFFF_FFFF_0000);
    queue_pixels(2, PX_EXTREME, 1'b0);
    wait_drained();

    // size shrunk mid-frame: column 2 of row 2 becomes the last column of the drain row
    cfg_write(rgbconv_pkg::REG_WIDTH, 64'd4);
    cfg_write(rgbconv_pkg::REG_HEIGHT, 64'hFFFF);
    load_kernel(TAPS_MODEST);
    queue_pixels(10, PX_RANDOM, 1'b0);
    wait_drained();
    cfg_write(rgbconv_pkg::REG_WIDTH, 64'd1);
    cfg_write(rgbconv_pkg::REG_HEIGHT, 64'd1);
    queue_pixels(1, PX_RANDOM, 1'b0);
    wait_drained();

    // random frames, mostly small; some run back to back on the same setting
    fresh = 1'b1;
    random_items = 0;
    while (random_items < RANDOM_ITEMS) begin
      if (fresh || $urandom_range(0, 1) == 0) begin
        wait_drained();
        v = $urandom_range(0, 9);
        n = (v < 6) ? $urandom_range(1, 8) : (v < 9) ? $urandom_range(9, 32) : 0;
        cfg_write(rgbconv_pkg::REG_WIDTH, {32'($urandom), 20'($urandom), 12'(n)});
        n = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 6);
        cfg_write(rgbconv_pkg::REG_HEIGHT, {32'($urandom), 16'($urandom), 16'(n)});
        if (fresh || $urandom_range(0, 2) != 0) load_kernel(taps_style_t'($urandom_range(0, 2)));
        fresh = 1'b0;
      end
      n = eff_width() * (eff_height() + 1);
      queue_pixels(n, px_style_t'($urandom_range(0, 2)), $urandom_range(0, 3) == 0);
      random_items += n;
    end
    wait_drained();

    // burst frame; hold the sink once results flow so the input backs up
    cfg_write(rgbconv_pkg::REG_WIDTH, 64'd32);
    cfg_write(rgbconv_pkg::REG_HEIGHT, 64'd4);
    queue_pixels(eff_width() * (eff_height() + 1), PX_RANDOM, 1'b1);
    do @(negedge clk); while (source_q.size() > 100);
    @(posedge clk);
    hold_asks <= hold_asks + 1;
    wait_drained();

    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("rgb_3x3_convolution_replicate_edge: match");
    end else begin
      $display("rgb_3x3_convolution_replicate_edge: mismatch");
    end
    $finish;
  end

  // hang guard, several times the slowest legal run
  initial begin : watchdog
    #5_000_000;
    $display("rgb_3x3_convolution_replicate_edge: mismatch");
    $finish;
  end

endmodule

/* sim.f */
design/rgbconv_pkg.sv
design/rgbconv_ram.sv
design/rgb_3x3_convolution_replicate_edge.sv
dv/rgb_3x3_convolution_replicate_edge_tb.sv
